>>> rtl/core/frsd_pkg.sv
package frsd_pkg;

  // Field widths of one item and one result, of the error sum and of the Q14 fraction
  localparam int BRANCH_W = 2;
  localparam int STEP_W   = 8;
  localparam int RATIO_W  = 16;
  localparam int RUN_W    = 8;
  localparam int ERR_W    = 20;
  localparam int FRAC_W   = 14;

  // Stream bus widths, whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam int unsigned NUM_BRANCHES_DEF = 4;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SKIP_RUN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION_STEPS = CFG_IDX_W'(3);

  localparam logic [ERR_W-1:0]  THRESHOLD_RST = ERR_W'(1966);
  localparam logic [RUN_W-1:0]  MAX_RUN_RST   = RUN_W'(2);
  localparam logic [STEP_W-1:0] RETENTION_RST = '0;

  // Item kinds
  localparam logic OP_DECIDE  = 1'b0;
  localparam logic OP_OBSERVE = 1'b1;

  // Q2.14 one and the rounding offset of a Q14 product
  localparam logic [RATIO_W-1:0]   ONE_Q14    = RATIO_W'(16384);
  localparam logic [2*RATIO_W-1:0] ROUND_HALF = (2*RATIO_W)'(8192);

  typedef struct packed {
    logic              enable;
    logic [ERR_W-1:0]  error_threshold;
    logic [RUN_W-1:0]  max_skip_run;
    logic [STEP_W-1:0] retention_steps;
  } frsd_cfg_t;

  typedef struct packed {
    logic                op;
    logic [BRANCH_W-1:0] branch;
    logic [STEP_W-1:0]   step_num;
    logic [RATIO_W-1:0]  step_ratio;
  } frsd_item_t;

  typedef struct packed {
    logic             reuse;
    logic [RUN_W-1:0] run_length;
  } frsd_result_t;

endpackage

>>> rtl/core/feature_reuse_skip_decider_unit.sv
// Feature reuse skip decider.
// Input stream (s_*): one beat per item. s_tuser carries op (0 decide, 1 observe);
// s_tdata carries branch, step_num and step_ratio (unsigned Q2.14).
// Output stream (m_*): exactly one beat per input beat, in order, carrying
// reuse and run_length of the branch concerned.
// Config channel (cfg_*): one register write per beat, always ready; write only
// while no item is in flight.
// Path: an accepted beat waits in the input register and moves into the output
// register, which drives m_*, once that register is free.
// Throughput: one item per cycle while m_tready is high. Branch state is read,
// updated and written back in the cycle an item moves from the input register
// to the output register; the next item on that branch sees the new state at once.
// Stall: when m_tready is low the result holds in the output register, and one
// more beat is still taken into the input register before s_tready drops.
// Reset: both stages empty, registers at their defaults (reuse disabled),
// every branch at product one, zero error, zero run, no residual ready.
module feature_reuse_skip_decider_unit #(
  parameter int unsigned NUM_BRANCHES = frsd_pkg::NUM_BRANCHES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] branch, [9:2] step_num, [25:10] step_ratio, upper bits zero
  input  logic [frsd_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] op
  input  logic                                s_tuser,
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] reuse, [8:1] run_length, upper bits zero
  output logic [frsd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [frsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frsd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import frsd_pkg::*;

  frsd_cfg_t    cfg;
  frsd_item_t   in_item;
  logic         in_valid;
  frsd_result_t eng_res;
  frsd_result_t out_res;
  logic         out_valid;
  logic         advance;

  frsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held item into the output register whenever that slot frees up
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register: capture the beat, drop it once it has advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op         <= s_tuser;
      in_item.branch     <= s_tdata[BRANCH_W-1:0];
      in_item.step_num   <= s_tdata[BRANCH_W+STEP_W-1:BRANCH_W];
      in_item.step_ratio <= s_tdata[BRANCH_W+STEP_W+RATIO_W-1:BRANCH_W+STEP_W];
    end
  end

  // Branch state update commits on the same edge the result is registered
  frsd_engine #(
    .NUM_BRANCHES (NUM_BRANCHES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (eng_res)
  );

  // Output register: hold the result until the receiver takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eng_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W-1-RUN_W)'(0), out_res.run_length, out_res.reuse};

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted beat not held in input register");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("waiting item lost or changed");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach output register");

  a_reuse_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.reuse |-> out_res.run_length != '0)
    else $error("reuse reported with empty run");
`endif

endmodule

>>> rtl/core/frsd_cfg_regs.sv
module frsd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [frsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output frsd_pkg::frsd_cfg_t                cfg
);
  import frsd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.error_threshold <= THRESHOLD_RST;
      cfg.max_skip_run    <= MAX_RUN_RST;
      cfg.retention_steps <= RETENTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:          cfg.enable          <= cfg_data[0];
        REG_ERROR_THRESHOLD: cfg.error_threshold <= cfg_data[ERR_W-1:0];
        REG_MAX_SKIP_RUN:    cfg.max_skip_run    <= cfg_data[RUN_W-1:0];
        REG_RETENTION_STEPS: cfg.retention_steps <= cfg_data[STEP_W-1:0];
        default:             ;
      endcase
    end
  end

endmodule

>>> rtl/core/frsd_engine.sv
module frsd_engine #(
  parameter int unsigned NUM_BRANCHES = frsd_pkg::NUM_BRANCHES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   commit,
  input  frsd_pkg::frsd_item_t   item,
  input  frsd_pkg::frsd_cfg_t    cfg,
  output frsd_pkg::frsd_result_t result
);
  import frsd_pkg::*;

  localparam int IDX_W    = (NUM_BRANCHES > 1) ? $clog2(NUM_BRANCHES) : 1;
  localparam int SCALED_W = 2*RATIO_W - FRAC_W;

  logic [RATIO_W-1:0]      ratio_product [NUM_BRANCHES];
  logic [ERR_W-1:0]        error_sum     [NUM_BRANCHES];
  logic [RUN_W-1:0]        skip_run      [NUM_BRANCHES];
  logic [NUM_BRANCHES-1:0] residual_ready;

  logic                   branch_ok;
  logic [IDX_W-1:0]       idx;
  logic [RATIO_W-1:0]     cur_prod;
  logic [ERR_W-1:0]       cur_err;
  logic [RUN_W-1:0]       cur_run;
  logic [2*RATIO_W-1:0]   mul;
  logic [2*RATIO_W-1:0]   rounded;
  logic [SCALED_W-1:0]    scaled;
  logic [RATIO_W-1:0]     new_prod;
  logic [RATIO_W-1:0]     step_err;
  logic [ERR_W:0]         err_wide;
  logic [ERR_W-1:0]       new_err;
  logic [RUN_W:0]         run_wide;
  logic                   fits;
  logic                   bypass;
  logic                   do_mark;
  logic                   do_store;
  logic                   do_clear;

  assign branch_ok = 32'(item.branch) < NUM_BRANCHES;
  assign idx       = branch_ok ? IDX_W'(item.branch) : '0;
  assign cur_prod  = ratio_product[idx];
  assign cur_err   = error_sum[idx];
  assign cur_run   = skip_run[idx];

  // Q2.14 product, rounded half up, saturated
  assign mul      = (2*RATIO_W)'(cur_prod) * (2*RATIO_W)'(item.step_ratio);
  assign rounded  = mul + ROUND_HALF;
  assign scaled   = rounded[2*RATIO_W-1:FRAC_W];
  assign new_prod = (|scaled[SCALED_W-1:RATIO_W]) ? '1 : scaled[RATIO_W-1:0];

  assign step_err = (new_prod >= ONE_Q14) ? new_prod - ONE_Q14 : ONE_Q14 - new_prod;
  assign err_wide = {1'b0, cur_err} + (ERR_W+1)'(step_err);
  assign new_err  = err_wide[ERR_W] ? '1 : err_wide[ERR_W-1:0];
  assign run_wide = {1'b0, cur_run} + (RUN_W+1)'(1);

  assign fits   = (new_err <= cfg.error_threshold) && (run_wide <= {1'b0, cfg.max_skip_run});
  assign bypass = !cfg.enable || (item.step_num < cfg.retention_steps) ||
                  !residual_ready[idx];

  assign do_mark  = branch_ok && (item.op == OP_OBSERVE) && cfg.enable;
  assign do_store = branch_ok && (item.op == OP_DECIDE) && !bypass && fits;
  assign do_clear = branch_ok && (item.op == OP_DECIDE) && !bypass && !fits;

  always_comb begin
    result.reuse = do_store;
    if (!branch_ok || do_clear) begin
      result.run_length = '0;
    end else if (do_store) begin
      result.run_length = run_wide[RUN_W-1:0];
    end else begin
      result.run_length = cur_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BRANCHES; i++) begin
        ratio_product[i] <= ONE_Q14;
        error_sum[i]     <= '0;
        skip_run[i]      <= '0;
      end
      residual_ready <= '0;
    end else if (commit) begin
      if (do_mark) begin
        residual_ready[idx] <= 1'b1;
      end
      if (do_store) begin
        ratio_product[idx] <= new_prod;
        error_sum[idx]     <= new_err;
        skip_run[idx]      <= run_wide[RUN_W-1:0];
      end
      if (do_clear) begin
        ratio_product[idx] <= ONE_Q14;
        error_sum[idx]     <= '0;
        skip_run[idx]      <= '0;
      end
    end
  end

endmodule
